[src/i2cms_pkg.sv]
package i2cms_pkg;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ      = 3'd3,
        OP_SEND_ACK  = 3'd4,
        OP_READ_ACK  = 3'd5
    } op_t;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd720;
    localparam logic [1:0]  SUB_LAST          = 2'd2;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } res_item_t;

    typedef struct packed {
        logic       scl_set;
        logic       scl_val;
        logic       sda_set;
        logic       sda_val;
        logic       rx_set;
        logic [2:0] rx_idx;
        logic       ack_set;
        logic       ack_val;
    } phase_act_t;

    function automatic logic [4:0] op_len(input op_t op);
        logic [4:0] len;
        case (op)
            OP_START:    len = 5'd4;
            OP_STOP:     len = 5'd3;
            OP_WRITE:    len = 5'd24;
            OP_READ:     len = 5'd25;
            OP_SEND_ACK: len = 5'd3;
            OP_READ_ACK: len = 5'd4;
            default:     len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

[src/i2cms_chan_if.sv]
interface i2cms_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/i2cms_phase_decode.sv]
module i2cms_phase_decode
    import i2cms_pkg::*;
(
    input  op_t        op,
    input  logic [4:0] phase,
    input  logic [1:0] sub,
    input  logic [2:0] bit_idx,
    input  logic [7:0] shift_out,
    input  logic       sda_in,
    output phase_act_t act
);

    always_comb
    begin
        act        = '0;
        act.rx_idx = ~bit_idx;
        case (op)
            OP_START:
            begin
                if (phase == 5'd0)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = 1'b1;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b1;
                end
                else if (phase == 5'd2)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = 1'b0;
                end
                else
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            OP_STOP:
            begin
                if (phase == 5'd0)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = 1'b0;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b1;
                end
                else
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (sub == 2'd0)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = shift_out[~bit_idx];
                end
                else if (sub == 2'd1)
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b1;
                end
                else
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            OP_READ:
            begin
                if (phase == 5'd0)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = 1'b1;
                end
                else if (sub == 2'd0)
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b1;
                end
                else if (sub == 2'd1)
                begin
                    act.rx_set = sda_in;
                end
                else
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            OP_SEND_ACK:
            begin
                if (phase == 5'd0)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = shift_out[0];
                end
                else if (phase == 5'd1)
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b1;
                end
                else
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
            default:
            begin
                if (phase == 5'd0)
                begin
                    act.sda_set = 1'b1;
                    act.sda_val = 1'b1;
                end
                else if (phase == 5'd1)
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b1;
                end
                else if (phase == 5'd2)
                begin
                    act.ack_set = 1'b1;
                    act.ack_val = sda_in;
                end
                else
                begin
                    act.scl_set = 1'b1;
                    act.scl_val = 1'b0;
                end
            end
        endcase
    end

endmodule

[src/i2c_master_bit_sequencer.sv]
// Open-drain I2C master bit engine. Every cmd beat is one tick of the timebase and
// produces exactly one registered res beat; one beat is taken per clock, held
// back only while an unread res beat sits in the output register. A command
// (start, stop, write byte, read byte, send ack, read ack) starts only on an idle
// engine, otherwise it is dropped, as are func codes 6 and 7. Each command runs
// a fixed list of pin phases (4, 3, 24, 25, 3 and 4 phases), each lasting
// phase_ticks beats of a TIMER_WIDTH-bit timer, zero counting as one; it resets to
// 720, and the user writes it through cfg while the engine is idle, unenforced.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    i2cms_chan_if.sink   cmd,
    i2cms_chan_if.source res,
    i2cms_chan_if.sink   cfg
);

    logic [15:0]            phase_ticks_reg;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    op_t                    op_reg, op_next;
    logic [4:0]             phase_reg, phase_next;
    logic [1:0]             sub_reg, sub_next;
    logic [2:0]             bit_reg, bit_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic [7:0]             shift_out_reg, shift_out_next;
    logic [7:0]             shift_in_reg, shift_in_next;
    logic                   ack_reg, ack_next;
    logic                   busy_reg, busy_next;
    logic                   done_next;
    logic                   res_valid_reg;
    res_item_t              res_reg;

    cmd_item_t              item;
    logic                   accept;
    logic                   start_cmd;
    op_t                    op_cur;
    logic [4:0]             phase_cur;
    logic [1:0]             sub_cur;
    logic [2:0]             bit_cur;
    logic [TIMER_WIDTH-1:0] tick_cur;
    logic [TIMER_WIDTH-1:0] lim_raw;
    logic [TIMER_WIDTH-1:0] lim_eff;
    logic [TIMER_WIDTH:0]   tick_inc;
    logic [4:0]             phase_inc;
    phase_act_t             act;

    assign item      = cmd.payload;
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign start_cmd = !busy_reg && item.cmd_valid && (item.func <= OP_READ_ACK);
    assign op_cur    = start_cmd ? op_t'(item.func) : op_reg;
    assign phase_cur = start_cmd ? 5'd0 : phase_reg;
    assign sub_cur   = start_cmd ? 2'd0 : sub_reg;
    assign bit_cur   = start_cmd ? 3'd0 : bit_reg;
    assign tick_cur  = start_cmd ? '0 : tick_reg;

    assign lim_raw   = TIMER_WIDTH'(phase_ticks_reg);
    assign lim_eff   = (lim_raw == '0) ? TIMER_WIDTH'(1) : lim_raw;
    assign tick_inc  = {1'b0, tick_cur} + (TIMER_WIDTH+1)'(1);
    assign phase_inc = phase_cur + 5'd1;

    i2cms_phase_decode u_decode (
        .op        (op_cur),
        .phase     (phase_cur),
        .sub       (sub_cur),
        .bit_idx   (bit_cur),
        .shift_out (shift_out_next),
        .sda_in    (item.sda_in),
        .act       (act)
    );

    always_comb
    begin
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        if (start_cmd && (op_t'(item.func) == OP_WRITE))
        begin
            shift_out_next = item.tx_byte;
        end
        else if (start_cmd && (op_t'(item.func) == OP_SEND_ACK))
        begin
            shift_out_next = {7'd0, item.ack_level};
        end
        else if (start_cmd && (op_t'(item.func) == OP_READ))
        begin
            shift_in_next = '0;
        end

        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        op_next    = op_cur;
        phase_next = phase_cur;
        sub_next   = sub_cur;
        bit_next   = bit_cur;
        tick_next  = tick_cur;
        busy_next  = busy_reg || start_cmd;
        done_next  = 1'b0;

        if (busy_next)
        begin
            if (tick_cur == '0)
            begin
                if (act.scl_set)
                begin
                    scl_next = act.scl_val;
                end
                if (act.sda_set)
                begin
                    sda_next = act.sda_val;
                end
                if (act.rx_set)
                begin
                    shift_in_next[act.rx_idx] = 1'b1;
                end
                if (act.ack_set)
                begin
                    ack_next = act.ack_val;
                end
            end

            if (tick_inc >= {1'b0, lim_eff})
            begin
                tick_next  = '0;
                phase_next = phase_inc;
                if (!((op_cur == OP_READ) && (phase_cur == 5'd0)))
                begin
                    if (sub_cur == SUB_LAST)
                    begin
                        sub_next = 2'd0;
                        bit_next = bit_cur + 3'd1;
                    end
                    else
                    begin
                        sub_next = sub_cur + 2'd1;
                    end
                end
                if (phase_inc >= op_len(op_cur))
                begin
                    busy_next  = 1'b0;
                    phase_next = 5'd0;
                    done_next  = 1'b1;
                end
            end
            else
            begin
                tick_next = tick_inc[TIMER_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            phase_ticks_reg <= cfg.payload;
        end
    end

    // engine state moves only when a tick beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            op_reg        <= OP_START;
            phase_reg     <= '0;
            sub_reg       <= '0;
            bit_reg       <= '0;
            tick_reg      <= '0;
            shift_out_reg <= '0;
            shift_in_reg  <= '0;
            ack_reg       <= 1'b1;
            busy_reg      <= 1'b0;
        end
        else if (accept)
        begin
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            bit_reg       <= bit_next;
            tick_reg      <= tick_next;
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
            ack_reg       <= ack_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg.scl_out  <= scl_next;
            res_reg.sda_out  <= sda_next;
            res_reg.busy_res <= busy_next;
            res_reg.done_res <= done_next;
            res_reg.rx_byte  <= shift_in_next;
            res_reg.ack_seen <= ack_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    localparam logic [2:0] FUNC_BAD_LO = 3'd6;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;
    localparam int OP_PHASES [6] = '{4, 3, 24, 25, 3, 4};
    localparam int LONG_HOLD = 400;
    localparam int WIDE_TICKS = 12;
    localparam int MODE_SRC_IDLE = 0;
    localparam int MODE_SINK_IDLE = 1;
    localparam int MODE_NO_IDLE = 2;
    localparam res_item_t IDLE_RES = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                       done_res: 1'b0, rx_byte: 8'h00, ack_seen: 1'b1};

    typedef struct {
        logic        valid;
        logic [2:0]  func;
        logic [7:0]  tx;
        logic        ack;
        int          ticks;
        bit          hold;
        logic [31:0] sda_pat;
        bit          typed;
        res_item_t   exp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    i2cms_chan_if #(.payload_t(cmd_item_t))   cmd_ch ();
    i2cms_chan_if #(.payload_t(res_item_t))   res_ch ();
    i2cms_chan_if #(.payload_t(logic [15:0])) cfg_ch ();

    i2c_master_bit_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // bus engine mirror
    logic [15:0] phase_len;
    logic        bus_scl;
    logic        bus_sda;
    op_t         eng_op;
    int          eng_phase;
    int          eng_ticks;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic        ack_sampled;
    logic        eng_busy;

    res_item_t   pending_bus_states[$];
    dir_row_t    rows[$];

    int errors;
    int ticks_sent;
    int beats_checked;
    int op_hits [6];
    int mode;
    int src_gap_pct;
    int sink_gap_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic res_item_t next_bus_state(input cmd_item_t c);
        res_item_t r;
        int p;
        int q;
        int lim;
        logic done;
        done = 1'b0;
        if (!eng_busy && c.cmd_valid && c.func <= OP_READ_ACK) begin
            eng_busy = 1'b1;
            eng_op = op_t'(c.func);
            eng_phase = 0;
            eng_ticks = 0;
            op_hits[c.func]++;
            case (eng_op)
                OP_WRITE:    tx_shift = c.tx_byte;
                OP_SEND_ACK: tx_shift = {7'd0, c.ack_level};
                OP_READ:     rx_shift = 8'h00;
                default:     ;
            endcase
        end
        if (eng_busy) begin
            if (eng_ticks == 0) begin
                p = eng_phase;
                case (eng_op)
                    OP_START: begin
                        if (p == 0) bus_sda = 1'b1;
                        else if (p == 1) bus_scl = 1'b1;
                        else if (p == 2) bus_sda = 1'b0;
                        else bus_scl = 1'b0;
                    end
                    OP_STOP: begin
                        if (p == 0) bus_sda = 1'b0;
                        else if (p == 1) bus_scl = 1'b1;
                        else bus_sda = 1'b1;
                    end
                    OP_WRITE: begin
                        q = p % 3;
                        if (q == 0) bus_sda = tx_shift[7 - p / 3];
                        else bus_scl = (q == 1);
                    end
                    OP_READ: begin
                        if (p == 0) bus_sda = 1'b1;
                        else begin
                            q = (p - 1) % 3;
                            if (q == 0) bus_scl = 1'b1;
                            else if (q == 1) begin
                                if (c.sda_in) rx_shift[7 - (p - 1) / 3] = 1'b1;
                            end
                            else bus_scl = 1'b0;
                        end
                    end
                    OP_SEND_ACK: begin
                        if (p == 0) bus_sda = tx_shift[0];
                        else bus_scl = (p == 1);
                    end
                    default: begin
                        if (p == 0) bus_sda = 1'b1;
                        else if (p == 1) bus_scl = 1'b1;
                        else if (p == 2) ack_sampled = c.sda_in;
                        else bus_scl = 1'b0;
                    end
                endcase
            end
            eng_ticks++;
            lim = (phase_len == 16'd0) ? 1 : int'(phase_len);
            if (eng_ticks >= lim) begin
                eng_ticks = 0;
                eng_phase++;
                if (eng_phase >= OP_PHASES[eng_op]) begin
                    eng_busy = 1'b0;
                    eng_phase = 0;
                    done = 1'b1;
                end
            end
        end
        r.scl_out  = bus_scl;
        r.sda_out  = bus_sda;
        r.busy_res = eng_busy;
        r.done_res = done;
        r.rx_byte  = rx_shift;
        r.ack_seen = ack_sampled;
        return r;
    endfunction

    task automatic set_mode(input int m);
        mode = m;
        src_gap_pct  = (m == MODE_SRC_IDLE) ? 24 : (m == MODE_SINK_IDLE) ? 83 : 0;
        sink_gap_pct = (m == MODE_SRC_IDLE) ? 83 : (m == MODE_SINK_IDLE) ? 24 : 0;
    endtask

    task automatic send_tick(input cmd_item_t it, input bit typed, input res_item_t typed_res);
        res_item_t r;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= it;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        r = next_bus_state(it);
        pending_bus_states.push_back(typed ? typed_res : r);
        ticks_sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_bus_states.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_phase_len(input logic [15:0] v);
        drain();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        phase_len = v;
    endtask

    // mostly whole commands on an idle engine, some noise and bad codes
    task automatic run_random(input int n_ticks);
        cmd_item_t it;
        int sent;
        int r;
        sent = 0;
        while (sent < n_ticks || eng_busy) begin
            it.sda_in    = $urandom_range(0, 1);
            it.tx_byte   = $urandom_range(0, 255);
            it.ack_level = $urandom_range(0, 1);
            it.func      = $urandom_range(0, 5);
            it.cmd_valid = 1'b0;
            r = $urandom_range(0, 99);
            if (!eng_busy && sent < n_ticks) begin
                if (r < 6) begin
                    it.cmd_valid = 1'b1;
                    it.func = $urandom_range(0, 1) ? FUNC_BAD_HI : FUNC_BAD_LO;
                end
                else if (r < 85) it.cmd_valid = 1'b1;
            end
            else if (r < 5) it.cmd_valid = 1'b1;
            send_tick(it, 1'b0, IDLE_RES);
            sent++;
        end
    endtask

    initial begin
        int mode2_cycles;
        int hold_left;
        bit held;
        mode2_cycles = 0;
        hold_left = 0;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (mode == MODE_NO_IDLE && !held && rst_n) begin
                mode2_cycles++;
                if (mode2_cycles >= 40) begin
                    held = 1'b1;
                    hold_left = LONG_HOLD;
                    res_ch.ready <= 1'b0;
                end
                else res_ch.ready <= 1'b1;
            end
            else res_ch.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
        end
    end

    always @(posedge clk) begin
        res_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_bus_states.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end
            else begin
                want = pending_bus_states.pop_front();
                beats_checked++;
                if (res_ch.payload.scl_out !== want.scl_out) begin
                    $error("scl_out expected %0b got %0b", want.scl_out, res_ch.payload.scl_out);
                    errors++;
                end
                if (res_ch.payload.sda_out !== want.sda_out) begin
                    $error("sda_out expected %0b got %0b", want.sda_out, res_ch.payload.sda_out);
                    errors++;
                end
                if (res_ch.payload.busy_res !== want.busy_res) begin
                    $error("busy_res expected %0b got %0b", want.busy_res,
                           res_ch.payload.busy_res);
                    errors++;
                end
                if (res_ch.payload.done_res !== want.done_res) begin
                    $error("done_res expected %0b got %0b", want.done_res,
                           res_ch.payload.done_res);
                    errors++;
                end
                if (res_ch.payload.rx_byte !== want.rx_byte) begin
                    $error("rx_byte expected %02h got %02h", want.rx_byte, res_ch.payload.rx_byte);
                    errors++;
                end
                if (res_ch.payload.ack_seen !== want.ack_seen) begin
                    $error("ack_seen expected %0b got %0b", want.ack_seen,
                           res_ch.payload.ack_seen);
                    errors++;
                end
            end
        end
    end

    initial begin
        cmd_item_t it;
        int k;
        errors = 0;
        ticks_sent = 0;
        beats_checked = 0;
        foreach (op_hits[i]) op_hits[i] = 0;
        phase_len   = PHASE_TICKS_RESET;
        bus_scl     = 1'b1;
        bus_sda     = 1'b1;
        eng_op      = OP_START;
        eng_phase   = 0;
        eng_ticks   = 0;
        tx_shift    = 8'h00;
        rx_shift    = 8'h00;
        ack_sampled = 1'b1;
        eng_busy    = 1'b0;
        set_mode(MODE_SRC_IDLE);

        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;

        // idle ticks and bad codes straight after reset leave the bus released, then every command runs
        rows.push_back('{1'b0, OP_START, 8'h00, 1'b0, 1, 1'b0, 32'h0, 1'b1, IDLE_RES});
        rows.push_back('{1'b1, FUNC_BAD_LO, 8'hFF, 1'b1, 1, 1'b0, 32'h0, 1'b1, IDLE_RES});
        rows.push_back('{1'b1, FUNC_BAD_HI, 8'h00, 1'b0, 1, 1'b0, 32'hF, 1'b1, IDLE_RES});
        rows.push_back('{1'b0, OP_WRITE, 8'hFF, 1'b1, 1, 1'b0, 32'hF, 1'b1, IDLE_RES});
        rows.push_back('{1'b1, OP_START, 8'h00, 1'b0, 4, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_WRITE, 8'h00, 1'b0, 24, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_READ_ACK, 8'h00, 1'b0, 4, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_WRITE, 8'hFF, 1'b1, 24, 1'b1, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_READ_ACK, 8'h00, 1'b0, 4, 1'b0, '1, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_WRITE, 8'hA5, 1'b0, 24, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_READ, 8'h00, 1'b0, 25, 1'b1, '1, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_SEND_ACK, 8'hFF, 1'b0, 3, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_READ, 8'hFF, 1'b1, 25, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_READ, 8'h00, 1'b0, 25, 1'b0, 32'hAAAAAAAA, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_SEND_ACK, 8'h00, 1'b1, 3, 1'b1, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_STOP, 8'h00, 1'b0, 3, 1'b0, 32'h0, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_STOP, 8'hFF, 1'b1, 3, 1'b0, '1, 1'b0, IDLE_RES});
        rows.push_back('{1'b1, OP_START, 8'hFF, 1'b1, 4, 1'b0, '1, 1'b0, IDLE_RES});
        rows.push_back('{1'b0, OP_STOP, 8'h00, 1'b0, 2, 1'b0, 32'h2, 1'b0, IDLE_RES});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_phase_len(16'd1);
        foreach (rows[i]) begin
            for (k = 0; k < rows[i].ticks; k++) begin
                it.cmd_valid = (k == 0 || rows[i].hold) ? rows[i].valid : 1'b0;
                it.func      = rows[i].func;
                it.tx_byte   = rows[i].tx;
                it.ack_level = rows[i].ack;
                it.sda_in    = rows[i].sda_pat[k % 32];
                send_tick(it, rows[i].typed, rows[i].exp);
            end
        end

        run_random(350);
        write_phase_len(16'd0);
        run_random(200);
        write_phase_len(16'd2);
        set_mode(MODE_SINK_IDLE);
        run_random(350);
        write_phase_len(16'd5);
        run_random(250);
        write_phase_len(16'd1);
        set_mode(MODE_NO_IDLE);
        run_random(300);
        write_phase_len(16'd3);
        run_random(300);

        // widest phase timer, the opening of a stop sequence
        write_phase_len(16'hFFFF);
        it.cmd_valid = 1'b1;
        it.func      = OP_STOP;
        it.tx_byte   = 8'h3C;
        it.ack_level = 1'b0;
        it.sda_in    = 1'b1;
        send_tick(it, 1'b0, IDLE_RES);
        it.cmd_valid = 1'b0;
        for (k = 1; k < WIDE_TICKS; k++) begin
            it.sda_in = k[0];
            send_tick(it, 1'b0, IDLE_RES);
        end

        drain();
        repeat (10) @(posedge clk);
        if (pending_bus_states.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_bus_states.size());
            errors++;
        end

        $display("covered %0d tick beats, %0d result beats checked, phase lengths 0..65535;",
                 ticks_sent, beats_checked);
        $display("commands run: start %0d, stop %0d, write %0d, read %0d, send ack %0d, %s %0d",
                 op_hits[OP_START], op_hits[OP_STOP], op_hits[OP_WRITE], op_hits[OP_READ],
                 op_hits[OP_SEND_ACK], "read ack", op_hits[OP_READ_ACK]);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
